// File: design/dram_row_close_policy_assert.svh
// Assertion macros used by the row close policy RTL.
`ifndef DRAM_ROW_CLOSE_POLICY_ASSERT_SVH
`define DRAM_ROW_CLOSE_POLICY_ASSERT_SVH

// Checks a consequent in the same cycle as its trigger.
`define DRCP_ASSERT_SAME(label, trig, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (expr)) else $error("assertion failed: label");

// Checks a consequent in the cycle after its trigger.
`define DRCP_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (expr)) else $error("assertion failed: label");

`endif

// File: design/drcp_pkg.sv
// Package with item types, register codes and command codes for the row close policy.
`timescale 1ns / 1ps
`default_nettype none

package drcp_pkg;

    // Command kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PRE    = 2'd1;
    localparam logic [1:0] KIND_ACCESS = 2'd2;

    // Request types.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;

    // Data classes.
    localparam logic [1:0] CLASS_WEIGHT = 2'd0;
    localparam logic [1:0] CLASS_KV     = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POLICY_MODE  = 2'd0;
    localparam logic [1:0] CFG_CLOSE_CAP    = 2'd1;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd2;

    localparam int CFG_DATA_BITS = 24;

    // Policy modes.
    localparam logic MODE_CAPPED   = 1'b0;
    localparam logic MODE_ADAPTIVE = 1'b1;

    localparam logic [23:0] CAP_RESET     = 24'd10000000;
    localparam logic [10:0] COLUMNS_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [1:0]  request_type;
        logic [1:0]  data_class;
        logic        rank_index;
        logic        group_all;
        logic [1:0]  group_index;
        logic        bank_all;
        logic [1:0]  bank_index;
        logic [15:0] row_address;
        logic [9:0]  column_address;
    } t_cmd_item;

    typedef struct packed {
        logic        issue_close;
        logic        close_rank;
        logic [1:0]  close_group;
        logic [1:0]  close_bank;
        logic [15:0] close_row;
        logic [31:0] closes_issued;
    } t_close_item;

    typedef struct packed {
        logic        policy_mode;
        logic [23:0] close_cap;
        logic [10:0] column_count;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/dram_row_close_policy.sv
// An accepted item passes the input register and then the result register before its result strobes.
// Throughput: one item per cycle; the bank counter read, update and write back all happen in the same cycle.
// Reset: synchronous, active low; clears all bank counters and the close total,
// and returns the registers to capped mode, a cap of 10000000 and 1024 columns.
// The receiver cannot stall: every result is shown for exactly one cycle on o_done.
`timescale 1ns / 1ps
`default_nettype none

module dram_row_close_policy
    import drcp_pkg::*;
#(
    parameter int NUM_RANKS  = 2,
    parameter int NUM_GROUPS = 4,
    parameter int NUM_BANKS  = 4,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire t_cmd_item                i_cmd,
    output logic                          o_done,
    output t_close_item                   o_result,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    `include "dram_row_close_policy_assert.svh"

    // The block never holds an item off: each command is settled in one pass.
    assign busy = 1'b0;

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy_mode  <= MODE_CAPPED;
            r_cfg.close_cap    <= CAP_RESET;
            r_cfg.column_count <= COLUMNS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLICY_MODE:  r_cfg.policy_mode  <= i_cfg_data[0];
                CFG_CLOSE_CAP:    r_cfg.close_cap    <= i_cfg_data[23:0];
                CFG_COLUMN_COUNT: r_cfg.column_count <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Input register: the accepted item waits here for its single pass.
    logic      r_in_valid;
    t_cmd_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_cmd;
    end

    // Counter file and policy decision. The counter chosen by the item is read,
    // judged and written back in the same cycle, so consecutive accesses to one
    // bank see each other's updates without any forwarding.
    logic                  access_ok;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] next_count;
    logic                  issue;

    drcp_counters #(
        .NUM_RANKS  (NUM_RANKS),
        .NUM_GROUPS (NUM_GROUPS),
        .NUM_BANKS  (NUM_BANKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .i_wr_count  (next_count),
        .o_access_ok (access_ok),
        .o_count     (count)
    );

    drcp_decide #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .i_cfg        (r_cfg),
        .i_item       (r_in),
        .i_access_ok  (access_ok),
        .i_count      (count),
        .o_issue      (issue),
        .o_next_count (next_count)
    );

    // Result register. The close address is zero unless a close is issued, and
    // the total reflects every close up to and including this item.
    logic        r_done;
    logic        r_issue;
    logic        r_rank;
    logic [1:0]  r_group;
    logic [1:0]  r_bank;
    logic [15:0] r_row;
    logic [31:0] r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_total <= '0;
        end else begin
            r_done <= r_in_valid;
            if (issue) begin
                r_total <= r_total + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue <= issue;
        r_rank  <= issue ? r_in.rank_index  : 1'b0;
        r_group <= issue ? r_in.group_index : 2'd0;
        r_bank  <= issue ? r_in.bank_index  : 2'd0;
        r_row   <= issue ? r_in.row_address : 16'd0;
    end

    assign o_done                 = r_done;
    assign o_result.issue_close   = r_issue;
    assign o_result.close_rank    = r_rank;
    assign o_result.close_group   = r_group;
    assign o_result.close_bank    = r_bank;
    assign o_result.close_row     = r_row;
    assign o_result.closes_issued = r_total;

    // An issued close advances the running total by exactly one.
    `DRCP_ASSERT_SAME(a_total_steps, o_done && o_result.issue_close, o_result.closes_issued == $past(o_result.closes_issued) + 32'd1)
    // Without a close the total does not move.
    `DRCP_ASSERT_SAME(a_total_holds, !(o_done && o_result.issue_close), $stable(o_result.closes_issued))
    // A close is only decided for an accepted access command.
    `DRCP_ASSERT_SAME(a_issue_needs_access, issue, r_in_valid && r_in.command_kind == KIND_ACCESS)
    // Every accepted item yields a result once it has passed the input and result registers.
    `DRCP_ASSERT_NEXT(a_item_to_result, start && !busy, ##1 o_done)

endmodule

`default_nettype wire

// File: design/drcp_counters.sv
// Per-bank column access counters with precharge clearing and access update.
`timescale 1ns / 1ps
`default_nettype none

module drcp_counters
    import drcp_pkg::*;
#(
    parameter int NUM_RANKS  = 2,
    parameter int NUM_GROUPS = 4,
    parameter int NUM_BANKS  = 4,
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_cmd_item             i_item,
    input  wire logic [COUNT_BITS-1:0] i_wr_count,
    output logic                       o_access_ok,
    output logic [COUNT_BITS-1:0]      o_count
);

    localparam int TABLE = NUM_RANKS * NUM_GROUPS * NUM_BANKS;
    localparam int IDX_W = (TABLE > 1) ? $clog2(TABLE) : 1;

    logic [COUNT_BITS-1:0] r_count [TABLE];
    logic [COUNT_BITS-1:0] n_count [TABLE];
    logic [IDX_W-1:0]      idx;
    logic                  is_pre;

    // An access counts only with real group and bank addresses in range.
    assign o_access_ok = i_valid && (i_item.command_kind == KIND_ACCESS) &&
                         !i_item.group_all && !i_item.bank_all &&
                         (32'(i_item.rank_index) < NUM_RANKS) &&
                         (32'(i_item.group_index) < NUM_GROUPS) &&
                         (32'(i_item.bank_index) < NUM_BANKS);

    assign idx = IDX_W'(32'(i_item.bank_index) +
                        32'(i_item.group_index) * NUM_BANKS +
                        32'(i_item.rank_index) * NUM_BANKS * NUM_GROUPS);

    assign o_count = r_count[idx];
    assign is_pre  = i_valid && (i_item.command_kind == KIND_PRE);

    always_comb begin
        for (int e = 0; e < TABLE; e++) begin
            int  r, g, b;
            logic clr;
            r = e / (NUM_BANKS * NUM_GROUPS);
            g = (e / NUM_BANKS) % NUM_GROUPS;
            b = e % NUM_BANKS;
            clr = 1'b0;
            if (is_pre && 32'(i_item.rank_index) == r) begin
                if (i_item.group_all && i_item.bank_all) begin
                    clr = 1'b1;
                end else if (i_item.group_all) begin
                    clr = (32'(i_item.bank_index) == b);
                end else if (!i_item.bank_all) begin
                    clr = (32'(i_item.bank_index) == b) &&
                          (32'(i_item.group_index) == g);
                end
            end
            n_count[e] = r_count[e];
            if (clr) begin
                n_count[e] = '0;
            end else if (o_access_ok && idx == IDX_W'(e)) begin
                n_count[e] = i_wr_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < TABLE; e++) begin
            if (!i_rst_n) begin
                r_count[e] <= '0;
            end else begin
                r_count[e] <= n_count[e];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/drcp_decide.sv
// Close decision and next counter value for one access.
`timescale 1ns / 1ps
`default_nettype none

module drcp_decide
    import drcp_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire t_cfg                  i_cfg,
    input  wire t_cmd_item             i_item,
    input  wire logic                  i_access_ok,
    input  wire logic [COUNT_BITS-1:0] i_count,
    output logic                       o_issue,
    output logic [COUNT_BITS-1:0]      o_next_count
);

    localparam int CMP_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;

    logic [COUNT_BITS-1:0] inc;
    logic                  last_col;
    logic                  want;

    assign inc = (i_count == {COUNT_BITS{1'b1}}) ? i_count : i_count + 1'b1;

    assign last_col = (i_cfg.column_count != 11'd0) &&
                      ({1'b0, i_item.column_address} == i_cfg.column_count - 11'd1);

    always_comb begin
        want = 1'b0;
        if (i_cfg.policy_mode == MODE_CAPPED) begin
            want = CMP_W'(inc) >= CMP_W'(i_cfg.close_cap);
        end else if (i_item.request_type == REQ_WRITE) begin
            want = (i_item.data_class == CLASS_KV) ||
                   ((i_item.data_class == CLASS_WEIGHT) && last_col);
        end else if (i_item.request_type == REQ_READ) begin
            want = last_col;
        end
    end

    assign o_issue      = i_access_ok && want;
    assign o_next_count = want ? '0 : inc;

endmodule

`default_nettype wire

// File: tb/drcp_checker.sv
// Checker that predicts and compares every close result of the row close policy.
`timescale 1ns / 1ps

module drcp_checker
    import drcp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire t_cmd_item                i_cmd,
    input  wire logic                     o_done,
    input  wire t_close_item              o_result,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                            o_failures,
    output int                            o_pending,
    output int                            o_results_checked,
    output int                            o_closes_seen
);

    localparam int          NUM_SLOTS = 32;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    logic [23:0]  bank_count [NUM_SLOTS];
    logic [31:0]  close_total;
    t_cfg         cfg_q;
    t_close_item  expected_closes [$];

    initial begin
        o_failures        = 0;
        o_pending         = 0;
        o_results_checked = 0;
        o_closes_seen     = 0;
    end

    // The slot of a bank is {rank, group, bank}, which equals
    // bank + group * 4 + rank * 16 for two ranks of four groups of four banks.
    function automatic t_close_item predict_close(input t_cmd_item c);
        t_close_item r;
        logic [4:0]  slot;
        logic        last_col;
        logic        issue;
        r     = '0;
        issue = 1'b0;
        slot  = {c.rank_index, c.group_index, c.bank_index};
        if (c.command_kind == KIND_PRE) begin
            if (c.group_all && c.bank_all) begin
                for (int g = 0; g < 4; g++) begin
                    for (int b = 0; b < 4; b++) begin
                        bank_count[{c.rank_index, 2'(g), 2'(b)}] = '0;
                    end
                end
            end else if (c.group_all) begin
                for (int g = 0; g < 4; g++) begin
                    bank_count[{c.rank_index, 2'(g), c.bank_index}] = '0;
                end
            end else if (!c.bank_all) begin
                bank_count[slot] = '0;
            end
        end else if (c.command_kind == KIND_ACCESS && !c.group_all && !c.bank_all) begin
            last_col = (cfg_q.column_count != 11'd0) &&
                       ({1'b0, c.column_address} == cfg_q.column_count - 11'd1);
            if (bank_count[slot] != COUNT_MAX) begin
                bank_count[slot] = bank_count[slot] + 24'd1;
            end
            if (cfg_q.policy_mode == MODE_CAPPED) begin
                issue = bank_count[slot] >= cfg_q.close_cap;
            end else if (c.request_type == REQ_WRITE) begin
                issue = (c.data_class == CLASS_KV) ||
                        (c.data_class == CLASS_WEIGHT && last_col);
            end else if (c.request_type == REQ_READ) begin
                issue = last_col;
            end
            if (issue) begin
                bank_count[slot] = '0;
                close_total      = close_total + 32'd1;
                r.issue_close    = 1'b1;
                r.close_rank     = c.rank_index;
                r.close_group    = c.group_index;
                r.close_bank     = c.bank_index;
                r.close_row      = c.row_address;
            end
        end
        r.closes_issued = close_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_close_item want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (bank_count[i]) bank_count[i] = '0;
            close_total        = '0;
            cfg_q.policy_mode  = MODE_CAPPED;
            cfg_q.close_cap    = CAP_RESET;
            cfg_q.column_count = COLUMNS_RESET;
            expected_closes.delete();
        end else begin
            // Results are compared before this edge's item is predicted, so a
            // strobe never pairs with an item accepted in the same cycle.
            if (o_done) begin
                if (expected_closes.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    errs++;
                end else begin
                    want = expected_closes.pop_front();
                    if (o_result.issue_close !== want.issue_close) begin
                        $error("issue_close: expected %0h, actual %0h",
                               want.issue_close, o_result.issue_close);
                        errs++;
                    end
                    if (o_result.close_rank !== want.close_rank) begin
                        $error("close_rank: expected %0h, actual %0h",
                               want.close_rank, o_result.close_rank);
                        errs++;
                    end
                    if (o_result.close_group !== want.close_group) begin
                        $error("close_group: expected %0h, actual %0h",
                               want.close_group, o_result.close_group);
                        errs++;
                    end
                    if (o_result.close_bank !== want.close_bank) begin
                        $error("close_bank: expected %0h, actual %0h",
                               want.close_bank, o_result.close_bank);
                        errs++;
                    end
                    if (o_result.close_row !== want.close_row) begin
                        $error("close_row: expected %0h, actual %0h",
                               want.close_row, o_result.close_row);
                        errs++;
                    end
                    if (o_result.closes_issued !== want.closes_issued) begin
                        $error("closes_issued: expected %0h, actual %0h",
                               want.closes_issued, o_result.closes_issued);
                        errs++;
                    end
                    o_results_checked <= o_results_checked + 1;
                    if (want.issue_close) o_closes_seen <= o_closes_seen + 1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY_MODE:  cfg_q.policy_mode  = i_cfg_data[0];
                    CFG_CLOSE_CAP:    cfg_q.close_cap    = i_cfg_data[23:0];
                    CFG_COLUMN_COUNT: cfg_q.column_count = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                expected_closes.push_back(predict_close(i_cmd));
            end
        end
        o_failures <= o_failures + errs;
        o_pending  <= expected_closes.size();
    end

endmodule

// File: tb/dram_row_close_policy_tb.sv
// Top of the row close policy testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module dram_row_close_policy_tb;
    import drcp_pkg::*;

    // Command kind 3 has no name in the package; it must behave as no command.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Register index 3 selects no register, so writes to it must change nothing.
    localparam logic [1:0] CFG_UNUSED  = 2'd3;

    localparam int NUM_PHASES       = 13;
    localparam int ITEMS_PER_PHASE  = 120;
    localparam int HOT_BANKS        = 3;
    localparam int IDLE_LIMIT       = 1000;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    t_cmd_item                i_cmd       = '0;
    logic                     o_done;
    t_close_item              o_result;
    logic                     i_cfg_we    = 1'b0;
    logic [1:0]               i_cfg_index = CFG_POLICY_MODE;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    int failures;
    int pending;
    int results_checked;
    int closes_seen;
    int items_sent  = 0;
    int idle_cycles = 0;

    t_cfg       phase_cfg [NUM_PHASES];
    logic [4:0] hot_addr  [HOT_BANKS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dram_row_close_policy u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    drcp_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .o_done            (o_done),
        .o_result          (o_result),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_failures        (failures),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_closes_seen     (closes_seen)
    );

    // The watchdog counts cycles in which no item is accepted and no result
    // strobes. A block that hangs in busy or stops producing results trips it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic t_cmd_item make_cmd(
        input logic [1:0]  kind,
        input logic [1:0]  rtype,
        input logic [1:0]  dclass,
        input logic        rank,
        input logic        gall,
        input logic [1:0]  group,
        input logic        ball,
        input logic [1:0]  bank,
        input logic [15:0] row,
        input logic [9:0]  col
    );
        t_cmd_item c;
        c.command_kind   = kind;
        c.request_type   = rtype;
        c.data_class     = dclass;
        c.rank_index     = rank;
        c.group_all      = gall;
        c.group_index    = group;
        c.bank_all       = ball;
        c.bank_index     = bank;
        c.row_address    = row;
        c.column_address = col;
        return c;
    endfunction

    // Random items are mostly well-formed accesses aimed at a few hot banks,
    // so that counters climb to the cap and closes actually happen. Some are
    // precharges that clear those banks, and a few are pure noise.
    function automatic t_cmd_item random_cmd(input t_cfg c);
        t_cmd_item  m;
        int         pick;
        int         h;
        int         col_pick;
        logic [9:0] last_col;
        m        = 39'({$urandom(), $urandom()});
        pick     = $urandom_range(0, 99);
        h        = $urandom_range(0, HOT_BANKS - 1);
        last_col = c.column_count[9:0] - 10'd1;
        if (pick < 8) begin
            return m;
        end
        if ($urandom_range(0, 3) != 0) begin
            {m.rank_index, m.group_index, m.bank_index} = hot_addr[h];
        end
        if (pick < 20) begin
            m.command_kind = KIND_PRE;
            return m;
        end
        m.command_kind = KIND_ACCESS;
        // Now and then an all marker rides on an access, which must be ignored.
        m.group_all = ($urandom_range(0, 19) == 0);
        m.bank_all  = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 5) != 0) m.request_type = {1'b0, 1'($urandom())};
        if ($urandom_range(0, 5) != 0) m.data_class   = {1'b0, 1'($urandom())};
        col_pick = $urandom_range(0, 9);
        if (col_pick < 3) begin
            m.column_address = last_col;
        end else if (col_pick == 3) begin
            m.column_address = 10'd0;
        end else if (col_pick == 4) begin
            m.column_address = 10'h3FF;
        end
        return m;
    endfunction

    // Hands one item to the block after a random wait. The item stays on the
    // port until an edge with start high and busy low takes it. When the next
    // item follows with no wait, start simply stays high.
    task automatic drive_cmd(input t_cmd_item c, input int gap_max);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // Drops start, waits until every expected result has come back, and lets
    // the two-stage pipeline settle before returning.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all registers on back-to-back edges while the block is idle.
    // Bits above a register's width carry random values, which the block
    // must drop. The unused index gets a random write as well.
    task automatic program_regs(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 24'($urandom());
        @(posedge i_clk);
        i_cfg_index <= CFG_POLICY_MODE;
        i_cfg_data  <= {23'($urandom()), c.policy_mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_CLOSE_CAP;
        i_cfg_data  <= c.close_cap;
        @(posedge i_clk);
        i_cfg_index <= CFG_COLUMN_COUNT;
        i_cfg_data  <= {13'($urandom()), c.column_count};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        t_cfg d;
        int   gap_max;

        // Register settings of the random phases. The extremes of the cap and
        // of the column count are here, a cap of zero and a column count of
        // zero among them, along with small random values that make closes
        // frequent.
        phase_cfg[0]  = '{MODE_CAPPED,   24'd1,                           11'd1024};
        phase_cfg[1]  = '{MODE_CAPPED,   24'd0,                           11'd1024};
        phase_cfg[2]  = '{MODE_CAPPED,   24'($urandom_range(2, 6)),       11'd1024};
        phase_cfg[3]  = '{MODE_CAPPED,   24'hFFFFFF,                      11'd0};
        phase_cfg[4]  = '{MODE_ADAPTIVE, 24'($urandom_range(1, 8)),       11'd1024};
        phase_cfg[5]  = '{MODE_ADAPTIVE, 24'hFFFFFF,                      11'd1};
        phase_cfg[6]  = '{MODE_ADAPTIVE, 24'd0,                           11'd0};
        phase_cfg[7]  = '{MODE_ADAPTIVE, 24'($urandom()),                 11'h7FF};
        phase_cfg[8]  = '{MODE_ADAPTIVE, 24'd3,                           11'($urandom_range(1, 16))};
        phase_cfg[9]  = '{MODE_CAPPED,   24'($urandom_range(3, 10)),      11'($urandom_range(1, 2047))};
        phase_cfg[10] = '{MODE_ADAPTIVE, 24'd2,                           11'd512};
        phase_cfg[11] = '{MODE_CAPPED,   CAP_RESET,                       COLUMNS_RESET};
        phase_cfg[12] = '{MODE_ADAPTIVE, 24'($urandom_range(1, 4)),       11'($urandom_range(1, 1024))};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Under the reset settings the cap is far away, so an
        // access at the last column closes nothing, and neither does a plain
        // no-op or the unused command kind.
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b0, 2'd0, 1'b0, 2'd0,
                           16'h0000, 10'h3FF), 18);
        drive_cmd(make_cmd(KIND_NONE, 2'd3, 2'd3, 1'b1, 1'b1, 2'd3, 1'b1, 2'd3,
                           16'hFFFF, 10'h3FF), 18);
        drive_cmd(make_cmd(KIND_UNUSED, REQ_WRITE, CLASS_KV, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'hFFFF, 10'h3FF), 0);
        drain();

        // A cap of two: every second access to a bank closes it, unless a
        // precharge in between has cleared the count.
        d = '{MODE_CAPPED, 24'd2, 11'd1024};
        program_regs(d);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_KV, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'hFFFF, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_KV, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'hFFFF, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'h1234, 10'h155), 5);
        // Both markers set: the whole rank is cleared.
        drive_cmd(make_cmd(KIND_PRE, REQ_READ, CLASS_WEIGHT, 1'b1, 1'b1, 2'd0, 1'b1, 2'd0,
                           16'h0000, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'hABCD, 10'h2AA), 3);
        // The bank marked all under a real group: the precharge is ignored.
        drive_cmd(make_cmd(KIND_PRE, REQ_WRITE, CLASS_KV, 1'b1, 1'b0, 2'd3, 1'b1, 2'd3,
                           16'h0000, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b1, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'h8001, 10'h001), 0);
        // Only the group marked all: that bank is cleared in every group.
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b0, 2'd1, 1'b0, 2'd2,
                           16'h00FF, 10'h100), 0);
        drive_cmd(make_cmd(KIND_PRE, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b1, 2'd0, 1'b0, 2'd2,
                           16'h0000, 10'h000), 7);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b0, 2'd1, 1'b0, 2'd2,
                           16'h00FF, 10'h100), 0);
        // All markers on an access: no count and no close.
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b1, 2'd1, 1'b0, 2'd2,
                           16'h00FF, 10'h100), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_WEIGHT, 1'b0, 1'b0, 2'd1, 1'b1, 2'd2,
                           16'h00FF, 10'h100), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_WEIGHT, 1'b0, 1'b0, 2'd1, 1'b0, 2'd2,
                           16'h7FFE, 10'h200), 0);
        // A single bank precharge.
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_KV, 1'b0, 1'b0, 2'd2, 1'b0, 2'd1,
                           16'h4000, 10'h010), 2);
        drive_cmd(make_cmd(KIND_PRE, REQ_READ, CLASS_KV, 1'b0, 1'b0, 2'd2, 1'b0, 2'd1,
                           16'h0000, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, CLASS_KV, 1'b0, 1'b0, 2'd2, 1'b0, 2'd1,
                           16'h4000, 10'h010), 0);
        drain();

        // Adaptive mode: KV-cache writes always close, weight writes and reads
        // close only at the last column, other request types never close.
        d = '{MODE_ADAPTIVE, 24'd2, 11'd1024};
        program_regs(d);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_KV, 1'b0, 1'b0, 2'd0, 1'b0, 2'd1,
                           16'h0005, 10'h005), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_WEIGHT, 1'b1, 1'b0, 2'd2, 1'b0, 2'd0,
                           16'hFFFF, 10'h3FF), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, CLASS_WEIGHT, 1'b1, 1'b0, 2'd2, 1'b0, 2'd0,
                           16'hFFFF, 10'h3FE), 4);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, 2'd3, 1'b0, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'h5A5A, 10'h3FF), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_READ, 2'd2, 1'b0, 1'b0, 2'd3, 1'b0, 2'd3,
                           16'h5A5A, 10'h000), 0);
        drive_cmd(make_cmd(KIND_ACCESS, 2'd2, CLASS_KV, 1'b1, 1'b0, 2'd1, 1'b0, 2'd1,
                           16'hA5A5, 10'h3FF), 0);
        drive_cmd(make_cmd(KIND_ACCESS, 2'd3, CLASS_KV, 1'b1, 1'b0, 2'd1, 1'b0, 2'd1,
                           16'hA5A5, 10'h3FF), 9);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, 2'd2, 1'b1, 1'b0, 2'd1, 1'b0, 2'd1,
                           16'hA5A5, 10'h3FF), 0);
        drive_cmd(make_cmd(KIND_ACCESS, REQ_WRITE, 2'd3, 1'b1, 1'b0, 2'd1, 1'b0, 2'd1,
                           16'hA5A5, 10'h3FF), 0);
        drain();

        // Random part. Each phase picks new hot banks and a wait profile:
        // some run with no gaps at all, others with short or long gaps.
        for (int p = 0; p < NUM_PHASES; p++) begin
            program_regs(phase_cfg[p]);
            foreach (hot_addr[h]) hot_addr[h] = 5'($urandom());
            case (p % 3)
                0:       gap_max = 18;
                1:       gap_max = 0;
                default: gap_max = 3;
            endcase
            repeat (ITEMS_PER_PHASE) drive_cmd(random_cmd(phase_cfg[p]), gap_max);
            drain();
        end

        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        $display("Covered %0d command items over %0d register settings.",
                 items_sent, NUM_PHASES + 3);
        $display("Checked %0d results, %0d of them with a row close.",
                 results_checked, closes_seen);
        if (failures == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
